@@ src/tpmc_pkg.sv @@
// Shared types and constants for the trend pattern match counter.
// No dependencies; used by every module in src.
package tpmc_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int CODE_W      = 2 * PATTERN_MAX;
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_CODE   = 1'd1;

  typedef enum logic [1:0] {
    CLASS_EQUAL = 2'd0,
    CLASS_UP    = 2'd1,
    CLASS_DOWN  = 2'd2
  } step_class_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      start_of_array;
  } in_word_t;

  typedef struct packed {
    logic               matched;
    logic [COUNT_W-1:0] match_count;
  } out_word_t;

  typedef struct packed {
    logic [LEN_W-1:0]  pattern_length;
    logic [CODE_W-1:0] pattern_code;
  } cfg_t;

endpackage

@@ src/tpmc_step_class.sv @@
// Previous-value register and up / equal / down step classifier.
// Depends on tpmc_pkg.
module tpmc_step_class (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic signed [tpmc_pkg::VALUE_W-1:0] value,
  output tpmc_pkg::step_class_t              cls
);

  logic signed [tpmc_pkg::VALUE_W-1:0] previous_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_value <= '0;
    end else if (advance) begin
      previous_value <= value;
    end
  end

  always_comb begin
    if (value > previous_value) begin
      cls = tpmc_pkg::CLASS_UP;
    end else if (value < previous_value) begin
      cls = tpmc_pkg::CLASS_DOWN;
    end else begin
      cls = tpmc_pkg::CLASS_EQUAL;
    end
  end

endmodule

@@ src/tpmc_matcher.sv @@
// Step history, fill count, pattern compare and saturating match count.
// Depends on tpmc_pkg.
module tpmc_matcher (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic                             start,
  input  tpmc_pkg::step_class_t            cls,
  input  tpmc_pkg::cfg_t                   cfg,
  output logic                             hit,
  output logic [tpmc_pkg::COUNT_W-1:0]     count_next
);

  logic [1:0]                     history      [tpmc_pkg::PATTERN_MAX];
  logic [1:0]                     history_next [tpmc_pkg::PATTERN_MAX];
  logic [tpmc_pkg::LEN_W-1:0]     fill;
  logic [tpmc_pkg::LEN_W-1:0]     fill_next;
  logic [tpmc_pkg::COUNT_W-1:0]   count;
  logic [tpmc_pkg::LEN_W-1:0]     m;
  logic [tpmc_pkg::IDX_W-1:0]     pos;
  logic [1:0]                     entry;
  logic                           all_equal;

  always_comb begin
    if (start) begin
      for (int i = 0; i < tpmc_pkg::PATTERN_MAX; i++) begin
        history_next[i] = 2'd0;
      end
      fill_next = '0;
    end else begin
      history_next[0] = cls;
      for (int i = 1; i < tpmc_pkg::PATTERN_MAX; i++) begin
        history_next[i] = history[i-1];
      end
      if (fill < tpmc_pkg::LEN_W'(tpmc_pkg::PATTERN_MAX)) begin
        fill_next = fill + 1'b1;
      end else begin
        fill_next = fill;
      end
    end
  end

  always_comb begin
    if (cfg.pattern_length > tpmc_pkg::LEN_W'(tpmc_pkg::PATTERN_MAX)) begin
      m = tpmc_pkg::LEN_W'(tpmc_pkg::PATTERN_MAX);
    end else begin
      m = cfg.pattern_length;
    end
    all_equal = 1'b1;
    pos       = '0;
    entry     = '0;
    for (int k = 0; k < tpmc_pkg::PATTERN_MAX; k++) begin
      if (tpmc_pkg::LEN_W'(k) < m) begin
        pos   = tpmc_pkg::IDX_W'(m - 1'b1 - tpmc_pkg::LEN_W'(k));
        entry = cfg.pattern_code[2*k +: 2];
        if (history_next[pos] != entry) begin
          all_equal = 1'b0;
        end
      end
    end
    hit = !start && (m != '0) && (fill_next >= m) && all_equal;
    if (start) begin
      count_next = '0;
    end else if (hit && (count != '1)) begin
      count_next = count + 1'b1;
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tpmc_pkg::PATTERN_MAX; i++) begin
        history[i] <= 2'd0;
      end
      fill  <= '0;
      count <= '0;
    end else if (advance) begin
      history <= history_next;
      fill    <= fill_next;
      count   <= count_next;
    end
  end

endmodule

@@ src/trend_pattern_match_counter.sv @@
// Trend pattern match counter top level: input register, configuration
// registers, result register. Depends on tpmc_pkg, tpmc_step_class, tpmc_matcher.
//
// Takes one word a cycle when not stalled and gives one result word per input
// word. An accepted word waits in the input register while the classifier and
// history compare work on it, and its result word is then captured in the
// result register. The input side stalls only when both registers are full and
// the result stall is high; otherwise a new word is accepted every cycle. Each
// step is classed as up, equal or down against the previous value, and a match
// is flagged when the last pattern_length classes, oldest first, equal the
// pattern entries; a start_of_array word clears history and count and yields no
// match. Write configuration only while the block is idle.
module trend_pattern_match_counter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  tpmc_pkg::in_word_t                  item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output tpmc_pkg::out_word_t                 result,
  input  logic                                cfg_write,
  input  logic [tpmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tpmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tpmc_pkg::cfg_t        cfg;
  tpmc_pkg::in_word_t    held;
  logic                  held_valid;
  logic                  advance;
  tpmc_pkg::step_class_t cls;
  logic                  hit;
  logic [tpmc_pkg::COUNT_W-1:0] count_next;

  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length <= tpmc_pkg::LEN_W'(1);
      cfg.pattern_code   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        tpmc_pkg::REG_PATTERN_LENGTH: begin
          cfg.pattern_length <= cfg_data[tpmc_pkg::LEN_W-1:0];
        end
        tpmc_pkg::REG_PATTERN_CODE: begin
          cfg.pattern_code <= cfg_data[tpmc_pkg::CODE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.matched     <= hit;
      result.match_count <= count_next;
    end
  end

  tpmc_step_class u_step_class (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .value   (held.value),
    .cls     (cls)
  );

  tpmc_matcher u_matcher (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .start      (held.start_of_array),
    .cls        (cls),
    .cfg        (cfg),
    .hit        (hit),
    .count_next (count_next)
  );

endmodule
